// ----- rtl/core/vec4_normalize_top_assert.svh -----
// assertion macros shared by the vec4 normalise rtl
`ifndef VEC4_NORMALIZE_TOP_ASSERT_SVH
`define VEC4_NORMALIZE_TOP_ASSERT_SVH

// same-cycle implication
`define V4N_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("v4n assertion failed");

// next-cycle implication
`define V4N_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("v4n assertion failed");

`endif

// ----- rtl/core/v4n_pkg.sv -----
// ----------------------------------------------------------------------------
// v4n_pkg
// shared widths and types of the vec4 normalise block
// ----------------------------------------------------------------------------
package v4n_pkg;

   localparam int UNIT_WIDTH   = 18;
   localparam int MAG_WIDTH    = 25;
   localparam int MINLEN_WIDTH = 17;
   localparam logic [MINLEN_WIDTH-1:0] MINLEN_RESET = 17'd7;

   typedef logic [UNIT_WIDTH-1:0]   unit_type;
   typedef logic [MAG_WIDTH-1:0]    mag_type;
   typedef logic [MINLEN_WIDTH-1:0] minlen_type;

endpackage

// ----- rtl/core/v4n_if.sv -----
// ----------------------------------------------------------------------------
// v4n interfaces
// request, response and csr channels of the vec4 normalise block
// ----------------------------------------------------------------------------
interface v4n_req_if #(parameter int IN_WIDTH = 24);
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] comp_x;
   logic signed [IN_WIDTH-1:0] comp_y;
   logic signed [IN_WIDTH-1:0] comp_z;
   logic signed [IN_WIDTH-1:0] comp_w;
   modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
   modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface v4n_rsp_if import v4n_pkg::*;;
   logic     valid;
   logic     ready;
   unit_type unit_x;
   unit_type unit_y;
   unit_type unit_z;
   unit_type unit_w;
   mag_type  magnitude;
   logic     degenerate;
   modport source (output valid, unit_x, unit_y, unit_z, unit_w, magnitude, degenerate,
                   input ready);
   modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, magnitude, degenerate,
                   output ready);
endinterface

interface v4n_csr_if import v4n_pkg::*;;
   logic       valid;
   logic       ready;
   minlen_type data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/vec4_normalize_top.sv -----
// ----------------------------------------------------------------------------
// vec4_normalize_top
// length and unit vector of a signed fixed point 4-component vector
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the output
// is not held, and each result passes through stages a to d, the square root
// chain, stage e, the divider chain and the output register. The depth is set
// by the square root chain, one cell per root bit, and the divider chain, one cell per quotient bit.
// The whole pipeline stalls only while a finished result waits on rsp ready.
// A length of zero, or one below min_length, gives the fallback vector
// (0, 1, 0, 0.04) with degenerate set; magnitude carries the clamped length.
// min_length is written through the csr channel, which is always ready, and
// should only be changed while no transaction is in flight.
`include "vec4_normalize_top_assert.svh"

module vec4_normalize_top import v4n_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int IN_WIDTH  = 24
) (
   input  logic clock,
   input  logic reset,
   v4n_req_if.sink   req_chan,
   v4n_rsp_if.source rsp_chan,
   v4n_csr_if.sink   csr_chan
);

   // derived widths
   localparam int SUMW = 2*IN_WIDTH + 1;     // sum of four squares
   localparam int NS   = 2*IN_WIDTH + 2;     // radicand padded to even width
   localparam int LW   = IN_WIDTH + 1;       // root / length
   localparam int RW   = LW + 3;             // sqrt remainder
   localparam int DW   = IN_WIDTH + 2;       // divider remainder
   localparam int QW   = FRAC_BITS + 1;      // quotient bits below saturation
   localparam int SPW  = 4*IN_WIDTH + 4;     // sqrt side payload
   localparam int DPW  = 4 + 4 + 1 + MAG_WIDTH;
   localparam int CW   = (LW > MAG_WIDTH) ? LW : MAG_WIDTH;
   localparam int EW   = (FRAC_BITS + 2 > UNIT_WIDTH) ? FRAC_BITS + 2 : UNIT_WIDTH;
   localparam longint ONE_L  = longint'(1) << FRAC_BITS;
   localparam longint FBW_L  = (ONE_L*4 + 50) / 100;
   localparam logic [QW-1:0]      ONE_Q   = QW'(ONE_L);
   localparam logic [UNIT_WIDTH-1:0] ONE_U = UNIT_WIDTH'(ONE_L);
   localparam logic [UNIT_WIDTH-1:0] FBW_U = UNIT_WIDTH'(FBW_L);
   localparam logic [CW-1:0]      MAG_MAX = CW'({MAG_WIDTH{1'b1}});

   // whole pipeline moves together unless the output register is held
   logic advance;

   // csr register
   minlen_type min_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MINLEN_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         min_length_ff <= csr_chan.data;
      end
   end

   assign csr_chan.ready = 1'b1;

   // stage a: absolute values and signs
   logic                               a_valid_ff;
   logic [3:0][IN_WIDTH-1:0]           a_mag_ff, a_mag_in, comp;
   logic [3:0]                         a_neg_ff, a_neg_in;

   always_comb begin
      comp[0] = req_chan.comp_x;
      comp[1] = req_chan.comp_y;
      comp[2] = req_chan.comp_z;
      comp[3] = req_chan.comp_w;
      for (int i = 0; i < 4; i++) begin
         a_neg_in[i] = comp[i][IN_WIDTH-1];
         a_mag_in[i] = a_neg_in[i] ? (~comp[i] + 1'b1) : comp[i];
      end
   end

   // stage b: squares
   logic                      b_valid_ff;
   logic [3:0][2*IN_WIDTH-1:0] b_sq_ff;
   logic [3:0][IN_WIDTH-1:0]   b_mag_ff;
   logic [3:0]                 b_neg_ff;

   // stage c: pair sums
   logic                       c_valid_ff;
   logic [1:0][2*IN_WIDTH:0]   c_pair_ff;
   logic [3:0][IN_WIDTH-1:0]   c_mag_ff;
   logic [3:0]                 c_neg_ff;

   // stage d: total sum of squares
   logic                       d_valid_ff;
   logic [SUMW-1:0]            d_sum_ff;
   logic [3:0][IN_WIDTH-1:0]   d_mag_ff;
   logic [3:0]                 d_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_chan.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_mag_ff <= a_mag_in;
         a_neg_ff <= a_neg_in;
         for (int i = 0; i < 4; i++) begin
            b_sq_ff[i] <= (2*IN_WIDTH)'(a_mag_ff[i]) * (2*IN_WIDTH)'(a_mag_ff[i]);
         end
         b_mag_ff     <= a_mag_ff;
         b_neg_ff     <= a_neg_ff;
         c_pair_ff[0] <= (2*IN_WIDTH+1)'(b_sq_ff[0]) + (2*IN_WIDTH+1)'(b_sq_ff[1]);
         c_pair_ff[1] <= (2*IN_WIDTH+1)'(b_sq_ff[2]) + (2*IN_WIDTH+1)'(b_sq_ff[3]);
         c_mag_ff     <= b_mag_ff;
         c_neg_ff     <= b_neg_ff;
         d_sum_ff     <= SUMW'(c_pair_ff[0]) + SUMW'(c_pair_ff[1]);
         d_mag_ff     <= c_mag_ff;
         d_neg_ff     <= c_neg_ff;
      end
   end

   // square root chain, one cell per root bit
   logic [LW:0]   sq_valid;
   logic [NS-1:0] sq_rad  [0:LW];
   logic [RW-1:0] sq_rem  [0:LW];
   logic [LW-1:0] sq_root [0:LW];
   logic [SPW-1:0] sq_side [0:LW];

   assign sq_valid[0] = d_valid_ff;
   assign sq_rad[0]   = NS'(d_sum_ff);
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = {d_mag_ff, d_neg_ff};

   for (genvar g = 0; g < LW; g++) begin : g_sqrt
      v4n_sqrt_cell #(.NS(NS), .LW(LW), .RW(RW), .PW(SPW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (sq_valid[g]),
         .in_rad    (sq_rad[g]),
         .in_rem    (sq_rem[g]),
         .in_root   (sq_root[g]),
         .in_side   (sq_side[g]),
         .out_valid (sq_valid[g+1]),
         .out_rad   (sq_rad[g+1]),
         .out_rem   (sq_rem[g+1]),
         .out_root  (sq_root[g+1]),
         .out_side  (sq_side[g+1])
      );
   end

   // stage e: threshold, magnitude clamp and divider set-up
   logic [LW-1:0]            len;
   logic [3:0][IN_WIDTH-1:0] e_mag;
   logic [3:0]               e_neg;
   logic [CW-1:0]            len_ext;
   logic                     e_valid_ff;
   logic [3:0][DW-1:0]       e_rem_ff, e_rem_in;
   logic [LW-1:0]            e_len_ff;
   logic [DPW-1:0]           e_side_ff, e_side_in;
   logic [3:0]               e_sat;
   logic                     e_degen;
   mag_type                  e_magsat;

   always_comb begin
      len              = sq_root[LW];
      {e_mag, e_neg}   = sq_side[LW];
      len_ext          = CW'(len);
      e_magsat         = (len_ext > MAG_MAX) ? {MAG_WIDTH{1'b1}} : MAG_WIDTH'(len_ext);
      e_degen          = (len == '0) || (len_ext < CW'(min_length_ff));
      for (int i = 0; i < 4; i++) begin
         // quotient at least two: saturates whatever the low bits
         e_sat[i]    = DW'(e_mag[i]) >= {len, 1'b0};
         e_rem_in[i] = DW'(e_mag[i]);
      end
      e_side_in = {e_neg, e_sat, e_degen, e_magsat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= sq_valid[LW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_rem_ff  <= e_rem_in;
         e_len_ff  <= len;
         e_side_ff <= e_side_in;
      end
   end

   // divider chain, one cell per quotient bit, four lanes abreast
   logic [QW:0]         dv_valid;
   logic [3:0][DW-1:0]  dv_rem  [0:QW];
   logic [3:0][QW-1:0]  dv_quo  [0:QW];
   logic [LW-1:0]       dv_len  [0:QW];
   logic [DPW-1:0]      dv_side [0:QW];

   assign dv_valid[0] = e_valid_ff;
   assign dv_rem[0]   = e_rem_ff;
   assign dv_quo[0]   = '0;
   assign dv_len[0]   = e_len_ff;
   assign dv_side[0]  = e_side_ff;

   for (genvar g = 0; g < QW; g++) begin : g_div
      v4n_div_cell #(.DW(DW), .LW(LW), .QW(QW), .PW(DPW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (dv_valid[g]),
         .in_rem    (dv_rem[g]),
         .in_quo    (dv_quo[g]),
         .in_len    (dv_len[g]),
         .in_side   (dv_side[g]),
         .out_valid (dv_valid[g+1]),
         .out_rem   (dv_rem[g+1]),
         .out_quo   (dv_quo[g+1]),
         .out_len   (dv_len[g+1]),
         .out_side  (dv_side[g+1])
      );
   end

   // output stage: saturate, restore sign, pick fallback
   logic [3:0]                  f_neg, f_sat;
   logic                        f_degen;
   mag_type                     f_magsat;
   logic [QW-1:0]               q_clip;
   logic [FRAC_BITS+1:0]        q_signed;
   logic signed [EW-1:0]        q_ext;
   logic [3:0][UNIT_WIDTH-1:0]  unit_in, unit_ff;
   logic                        out_valid_ff;
   logic                        degen_ff;
   mag_type                     mag_ff;
   logic                        unused_tail;

   // remainder and divisor copies past the last cell carry nothing further
   assign unused_tail = ^{dv_rem[QW], dv_len[QW], sq_rad[LW], sq_rem[LW]};

   always_comb begin
      {f_neg, f_sat, f_degen, f_magsat} = dv_side[QW];
      q_clip   = '0;
      q_signed = '0;
      q_ext    = '0;
      for (int i = 0; i < 4; i++) begin
         q_clip   = (f_sat[i] || (dv_quo[QW][i] > ONE_Q)) ? ONE_Q : dv_quo[QW][i];
         q_signed = f_neg[i] ? (~(FRAC_BITS+2)'(q_clip) + 1'b1) : (FRAC_BITS+2)'(q_clip);
         q_ext    = EW'(signed'(q_signed));
         unit_in[i] = q_ext[UNIT_WIDTH-1:0];
      end
      if (f_degen) begin
         unit_in[0] = '0;
         unit_in[1] = ONE_U;
         unit_in[2] = '0;
         unit_in[3] = FBW_U;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid[QW] | (unused_tail & 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         unit_ff  <= unit_in;
         degen_ff <= f_degen;
         mag_ff   <= f_magsat;
      end
   end

   assign advance            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready     = advance;
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.unit_x    = unit_ff[0];
   assign rsp_chan.unit_y    = unit_ff[1];
   assign rsp_chan.unit_z    = unit_ff[2];
   assign rsp_chan.unit_w    = unit_ff[3];
   assign rsp_chan.magnitude = mag_ff;
   assign rsp_chan.degenerate = degen_ff;

   // a held result blocks new requests
   `V4N_ASSERT_NOW(a_stall_blocks_req, clock, reset,
      rsp_chan.valid && !rsp_chan.ready, !req_chan.ready)
   // zero length always falls back
   `V4N_ASSERT_NOW(a_zero_len_degen, clock, reset,
      rsp_chan.valid && (rsp_chan.magnitude == '0), rsp_chan.degenerate)
   // fallback vector shape
   `V4N_ASSERT_NOW(a_fallback_shape, clock, reset,
      rsp_chan.valid && rsp_chan.degenerate,
      (rsp_chan.unit_x == '0) && (rsp_chan.unit_z == '0) && (rsp_chan.unit_y == ONE_U))
   // held result stays valid and keeps its magnitude
   `V4N_ASSERT_NEXT(a_hold_result, clock, reset,
      rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(rsp_chan.magnitude))

endmodule

// ----- rtl/core/v4n_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// v4n_sqrt_cell
// one root bit of a pipelined restoring integer square root
// ----------------------------------------------------------------------------
module v4n_sqrt_cell #(
   parameter int NS = 50,
   parameter int LW = 25,
   parameter int RW = 28,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [NS-1:0] in_rad,
   input  logic [RW-1:0] in_rem,
   input  logic [LW-1:0] in_root,
   input  logic [PW-1:0] in_side,
   output logic          out_valid,
   output logic [NS-1:0] out_rad,
   output logic [RW-1:0] out_rem,
   output logic [LW-1:0] out_root,
   output logic [PW-1:0] out_side
);

   logic          valid_ff;
   logic [NS-1:0] rad_ff, rad_in;
   logic [RW-1:0] rem_ff, rem_in, rem_sh, trial;
   logic [LW-1:0] root_ff, root_in;
   logic [PW-1:0] side_ff;

   always_comb begin
      rem_sh = {in_rem[RW-3:0], in_rad[NS-1:NS-2]};
      trial  = RW'({in_root, 2'b01});
      rad_in = {in_rad[NS-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {in_root[LW-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {in_root[LW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

// ----- rtl/core/v4n_div_cell.sv -----
// ----------------------------------------------------------------------------
// v4n_div_cell
// one quotient bit of four restoring dividers sharing a divisor
// ----------------------------------------------------------------------------
module v4n_div_cell #(
   parameter int DW = 26,
   parameter int LW = 25,
   parameter int QW = 17,
   parameter int PW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [3:0][DW-1:0]  in_rem,
   input  logic [3:0][QW-1:0]  in_quo,
   input  logic [LW-1:0]       in_len,
   input  logic [PW-1:0]       in_side,
   output logic                out_valid,
   output logic [3:0][DW-1:0]  out_rem,
   output logic [3:0][QW-1:0]  out_quo,
   output logic [LW-1:0]       out_len,
   output logic [PW-1:0]       out_side
);

   logic               valid_ff;
   logic [3:0][DW-1:0] rem_ff, rem_in;
   logic [3:0][QW-1:0] quo_ff, quo_in;
   logic [LW-1:0]      len_ff;
   logic [PW-1:0]      side_ff;
   logic [DW-1:0]      diff;

   always_comb begin
      diff = '0;
      for (int i = 0; i < 4; i++) begin
         if (in_rem[i] >= DW'(in_len)) begin
            diff      = in_rem[i] - DW'(in_len);
            quo_in[i] = {in_quo[i][QW-2:0], 1'b1};
         end else begin
            diff      = in_rem[i];
            quo_in[i] = {in_quo[i][QW-2:0], 1'b0};
         end
         rem_in[i] = {diff[DW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         len_ff  <= in_len;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_len   = len_ff;
   assign out_side  = side_ff;

endmodule
